// ----- rtl/core/tile_grid_ray_cast_macros.svh -----
// Assertion macros for the tile grid ray caster.
// Used by tile_grid_ray_cast.sv; expects clk and arst_n in scope.
`ifndef TILE_GRID_RAY_CAST_MACROS_SVH
`define TILE_GRID_RAY_CAST_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TGRC_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tile grid ray cast: assertion failed");

// Next-cycle implication, disabled during reset
`define TGRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tile grid ray cast: assertion failed");

`endif

// ----- rtl/core/tgrc_pkg.sv -----
// Shared constants for the tile grid ray caster: word kinds, register
// indexes and the fixed-point widths of the crossing arithmetic. No dependencies.
package tgrc_pkg;

	// word kinds on the command channel
	localparam logic [1:0] KIND_CELL = 2'd0;
	localparam logic [1:0] KIND_TYPE = 2'd1;
	localparam logic [1:0] KIND_CAST = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MAP_WIDTH   = 2'd0;
	localparam logic [1:0] REG_MAP_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_EMPTY_FLAGS = 2'd2;

	// fixed-point layout, signed Q9.8
	localparam int FRAC    = 8;
	localparam int COORD_W = 17;
	localparam int DELTA_W = COORD_W + 1;
	// cell counter (signed) and map size (unsigned), sizes up to 1024
	localparam int CW      = 12;
	localparam int SZW     = CW - 1;
	localparam int PW      = CW + FRAC;
	localparam int DPW     = PW + 1;
	// multiplier operands and product
	localparam int MW      = 22;
	localparam int PRODW   = 2 * MW;
	// divider: numerator magnitude, divisor, quotient
	localparam int NW      = 38;
	localparam int DENW    = DELTA_W;
	localparam int QW      = NW + 2;
	localparam int DCW     = 6;
	// other coordinate at a crossing, squared distance
	localparam int SW      = QW + 1;
	localparam int DW      = PRODW + 1;
	// wide enough to compare a tile index with the type count
	localparam int TYW     = 17;

endpackage

// ----- rtl/core/tile_grid_ray_cast.sv -----
// Tile grid ray caster: cell store, tile type flags, two axis crossing walks.
// A cell or type word is written as it is accepted. A cast is accepted from idle, then each
// walk runs a setup of one multiply and two 38-step divisions on the shared divider, visits
// its crossings and leaves; a zero-delta walk skips the multiply and divisions; then it finishes.
// Throughput: one word at a time; a cast holds off new words until its result is finished.
// Reset: a clearing pass zeroes the cell store.
`include "tile_grid_ray_cast_macros.svh"

module tile_grid_ray_cast #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int TILE_TYPES = 1023
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  logic [1:0]                           kind,
	input  logic [6:0]                           cell_x,
	input  logic [6:0]                           cell_y,
	input  logic [9:0]                           tile_num,
	input  logic [7:0]                           flag_bits,
	input  logic signed [tgrc_pkg::COORD_W-1:0]  start_x,
	input  logic signed [tgrc_pkg::COORD_W-1:0]  start_y,
	input  logic signed [tgrc_pkg::COORD_W-1:0]  end_x,
	input  logic signed [tgrc_pkg::COORD_W-1:0]  end_y,
	input  logic [7:0]                           filter_mask,
	// result channel
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic                                 hit,
	output logic signed [tgrc_pkg::COORD_W-1:0]  hit_x,
	output logic signed [tgrc_pkg::COORD_W-1:0]  hit_y,
	// configuration channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [7:0]                           cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TW    = (TILE_TYPES > 1) ? $clog2(TILE_TYPES) : 1;

	localparam int FRAC    = tgrc_pkg::FRAC;
	localparam int COORD_W = tgrc_pkg::COORD_W;
	localparam int DELTA_W = tgrc_pkg::DELTA_W;
	localparam int CW      = tgrc_pkg::CW;
	localparam int SZW     = tgrc_pkg::SZW;
	localparam int PW      = tgrc_pkg::PW;
	localparam int DPW     = tgrc_pkg::DPW;
	localparam int MW      = tgrc_pkg::MW;
	localparam int PRODW   = tgrc_pkg::PRODW;
	localparam int NW      = tgrc_pkg::NW;
	localparam int DENW    = tgrc_pkg::DENW;
	localparam int QW      = tgrc_pkg::QW;
	localparam int DCW     = tgrc_pkg::DCW;
	localparam int SW      = tgrc_pkg::SW;
	localparam int DW      = tgrc_pkg::DW;
	localparam int TYW     = tgrc_pkg::TYW;

	localparam logic signed [CW-1:0] C_ONE = CW'(1);

	typedef enum logic [16:0] {
		ST_CLEAR = 17'b00000000000000001,
		ST_IDLE  = 17'b00000000000000010,
		ST_SETUP = 17'b00000000000000100,
		ST_MUL   = 17'b00000000000001000,
		ST_DLD   = 17'b00000000000010000,
		ST_DIVA  = 17'b00000000000100000,
		ST_DIVB  = 17'b00000000001000000,
		ST_STEP  = 17'b00000000010000000,
		ST_RD1   = 17'b00000000100000000,
		ST_RD2   = 17'b00000001000000000,
		ST_SQ1   = 17'b00000010000000000,
		ST_SQ2   = 17'b00000100000000000,
		ST_SQ3   = 17'b00001000000000000,
		ST_NEXT  = 17'b00010000000000000,
		ST_LEN1  = 17'b00100000000000000,
		ST_LEN2  = 17'b01000000000000000,
		ST_FIN   = 17'b10000000000000000
	} state_t;

	typedef enum logic [1:0] {
		SRC_EMPTY = 2'd0,
		SRC_ZERO  = 2'd1,
		SRC_MEM   = 2'd2
	} src_t;

	state_t state_q;

	// configuration
	logic [7:0] map_width_q, map_height_q, empty_flags_q;
	logic [SZW-1:0] eff_w, eff_h;

	// cast word
	logic signed [COORD_W-1:0] sx_q, sy_q;
	logic signed [DELTA_W-1:0] rx_q, ry_q;
	logic [7:0] filt_q;
	logic       axis_q;

	// walk state
	logic signed [CW-1:0]  c_q;
	logic                  neg_q;
	logic [DENW-1:0]       den_q;
	logic signed [QW-1:0]  q_q, qi_q;
	logic [DENW-1:0]       r_q, ri_q;

	// shared divider
	logic [DENW-1:0] dv_rem_q;
	logic [NW-1:0]   dv_quo_q;
	logic            dv_neg_q;
	logic [DCW-1:0]  dv_cnt_q;

	// shared multiplier
	logic signed [MW-1:0]    ma, mb;
	logic signed [PRODW-1:0] prod_q;
	logic [PRODW-1:0]        prod_u;
	logic [PRODW-1:0]        sq_q;

	// best hit
	logic                      found_q;
	logic [DW-1:0]             best_d_q;
	logic signed [COORD_W-1:0] best_x_q, best_y_q, cand_x_q, cand_y_q;
	logic                      hit_bit_q;

	// memories
	logic [9:0] cell_mem [DEPTH];
	logic [7:0] type_mem [TILE_TYPES];
	logic [AW-1:0] clr_q;
	logic [9:0] tile_rd_q;
	logic [7:0] flag_rd_q;
	logic       off_q;
	src_t       src_q;

	// result register
	logic                      res_valid_q;
	logic                      res_hit_q;
	logic signed [COORD_W-1:0] res_x_q, res_y_q;

	logic cmd_acc;
	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;

	assign res_valid = res_valid_q;
	assign hit       = res_hit_q;
	assign hit_x     = res_x_q;
	assign hit_y     = res_y_q;

	// clamp map size to the store
	assign eff_w = (SZW'(map_width_q) < SZW'(MAX_WIDTH)) ? SZW'(map_width_q) : SZW'(MAX_WIDTH);
	assign eff_h = (SZW'(map_height_q) < SZW'(MAX_HEIGHT)) ?
		SZW'(map_height_q) : SZW'(MAX_HEIGHT);

	// select the walked axis
	logic signed [COORD_W-1:0] p0, s0;
	logic signed [DELTA_W-1:0] dp, ds;
	logic [SZW-1:0]            plim, slim;
	logic signed [CW-1:0]      plim_s;
	assign p0     = axis_q ? sy_q : sx_q;
	assign s0     = axis_q ? sx_q : sy_q;
	assign dp     = axis_q ? ry_q : rx_q;
	assign ds     = axis_q ? rx_q : ry_q;
	assign plim   = axis_q ? eff_h : eff_w;
	assign slim   = axis_q ? eff_w : eff_h;
	assign plim_s = {1'b0, plim};

	// first crossing cell
	logic signed [COORD_W-FRAC-1:0] p0_int;
	logic signed [CW-1:0]           c0;
	assign p0_int = p0[COORD_W-1:FRAC];
	assign c0     = CW'(p0_int) + (dp[DELTA_W-1] ? -C_ONE : C_ONE);

	// crossing line position and offset from the start
	logic signed [CW-1:0]  pc;
	logic signed [PW-1:0]  p_cur;
	logic signed [DPW-1:0] dpp, diffsg;
	assign pc     = neg_q ? c_q + C_ONE : c_q;
	assign p_cur  = {pc, {FRAC{1'b0}}};
	assign dpp    = DPW'(p_cur) - DPW'(p0);
	assign diffsg = neg_q ? -dpp : dpp;

	// magnitudes of the walk deltas
	logic [DELTA_W-1:0] dp_abs, ds_abs;
	assign dp_abs = dp[DELTA_W-1] ? DELTA_W'(-dp) : DELTA_W'(dp);
	assign ds_abs = ds[DELTA_W-1] ? DELTA_W'(-ds) : DELTA_W'(ds);

	// other coordinate at the crossing and its cell
	logic signed [SW-1:0] s_cur;
	logic                 s_oob;
	logic [SZW-1:0]       sc_cell, c_cell;
	logic                 c_off, loop_ok;
	logic [SZW-1:0]       rd_x, rd_y;
	logic [AW-1:0]        rd_addr;
	assign s_cur   = SW'(s0) + SW'(q_q);
	assign s_oob   = s_cur[SW-1] || (s_cur >= SW'({slim, {FRAC{1'b0}}}));
	assign sc_cell = s_cur[FRAC+SZW-1:FRAC];
	assign c_cell  = c_q[SZW-1:0];
	assign c_off   = c_q[CW-1] || (c_q >= plim_s);
	assign loop_ok = neg_q ? !c_q[CW-1] : (c_q < plim_s);
	assign rd_x    = axis_q ? sc_cell : c_cell;
	assign rd_y    = axis_q ? c_cell : sc_cell;
	assign rd_addr = AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x);

	// divider step and floor correction
	logic [DENW:0]   dv_sh;
	logic            dv_ge;
	logic [DENW-1:0] dv_rem_n;
	logic signed [QW-1:0] dv_qmag, fin_q;
	logic [DENW-1:0] fin_r;
	logic [NW-1:0]   prod_mag;
	assign dv_sh    = {dv_rem_q, dv_quo_q[NW-1]};
	assign dv_ge    = dv_sh >= {1'b0, den_q};
	assign dv_rem_n = dv_ge ? DENW'(dv_sh - {1'b0, den_q}) : DENW'(dv_sh);
	assign dv_qmag  = QW'(dv_quo_q);
	always_comb begin
		if (dv_neg_q && (dv_rem_q != '0)) begin
			fin_q = -dv_qmag - QW'(1);
			fin_r = den_q - dv_rem_q;
		end else if (dv_neg_q) begin
			fin_q = -dv_qmag;
			fin_r = dv_rem_q;
		end else begin
			fin_q = dv_qmag;
			fin_r = dv_rem_q;
		end
	end
	assign prod_mag = prod_q[PRODW-1] ? NW'(-prod_q) : NW'(prod_q);

	// advance to the next crossing
	logic [DENW:0]        r_sum;
	logic                 r_wrap;
	assign r_sum  = {1'b0, r_q} + {1'b0, ri_q};
	assign r_wrap = r_sum >= {1'b0, den_q};

	// tile flags of the current cell
	logic [7:0] cell_f;
	always_comb begin
		case (src_q)
			SRC_EMPTY: cell_f = empty_flags_q;
			SRC_ZERO:  cell_f = 8'd0;
			SRC_MEM:   cell_f = flag_rd_q;
			default:   cell_f = 8'd0;
		endcase
	end

	// squared distance
	logic [DW-1:0] sq_sum;
	assign prod_u = prod_q;
	assign sq_sum = DW'(sq_q) + DW'(prod_u);

	// multiplier operand select
	always_comb begin
		case (state_q)
			ST_MUL: begin
				ma = MW'(ds);
				mb = MW'(diffsg);
			end
			ST_SQ1: begin
				ma = MW'(dpp);
				mb = MW'(dpp);
			end
			ST_SQ2: begin
				ma = MW'(q_q);
				mb = MW'(q_q);
			end
			ST_NEXT: begin
				ma = MW'(rx_q);
				mb = MW'(rx_q);
			end
			ST_LEN1: begin
				ma = MW'(ry_q);
				mb = MW'(ry_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	// cell store write port: clearing pass or cell word
	logic          cell_we;
	logic [AW-1:0] cell_wa;
	logic [9:0]    cell_wd;
	always_comb begin
		cell_we = 1'b0;
		cell_wa = AW'(cell_y) * AW'(MAX_WIDTH) + AW'(cell_x);
		cell_wd = tile_num;
		if (state_q == ST_CLEAR) begin
			cell_we = 1'b1;
			cell_wa = clr_q;
			cell_wd = '0;
		end else if (cmd_acc && (kind == tgrc_pkg::KIND_CELL) &&
				(32'(cell_x) < MAX_WIDTH) && (32'(cell_y) < MAX_HEIGHT)) begin
			cell_we = 1'b1;
		end
	end

	// type table write port
	logic          type_we;
	logic [9:0]    tile_in_m1, tile_rd_m1;
	assign tile_in_m1 = tile_num - 10'd1;
	assign tile_rd_m1 = tile_rd_q - 10'd1;
	assign type_we = cmd_acc && (kind == tgrc_pkg::KIND_TYPE) && (tile_num != '0) &&
		(TYW'(tile_num) <= TYW'(TILE_TYPES));

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
		tile_rd_q <= cell_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (type_we) begin
			type_mem[TW'(tile_in_m1)] <= flag_bits;
		end
		flag_rd_q <= type_mem[TW'(tile_rd_m1)];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q   <= 8'd128;
			map_height_q  <= 8'd128;
			empty_flags_q <= 8'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				tgrc_pkg::REG_MAP_WIDTH:   map_width_q   <= cfg_data;
				tgrc_pkg::REG_MAP_HEIGHT:  map_height_q  <= cfg_data;
				tgrc_pkg::REG_EMPTY_FLAGS: empty_flags_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			axis_q      <= 1'b0;
			found_q     <= 1'b0;
			dv_cnt_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// drop the result word once taken; the finish step reloads it itself
			if (res_valid_q && !res_stall && (state_q != ST_FIN)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_acc && (kind == tgrc_pkg::KIND_CAST)) begin
						sx_q     <= start_x;
						sy_q     <= start_y;
						rx_q     <= DELTA_W'(end_x) - DELTA_W'(start_x);
						ry_q     <= DELTA_W'(end_y) - DELTA_W'(start_y);
						filt_q   <= filter_mask;
						found_q  <= 1'b0;
						best_d_q <= '0;
						best_x_q <= end_x;
						best_y_q <= end_y;
						axis_q   <= 1'b0;
						state_q  <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (dp == '0) begin
						state_q <= ST_NEXT;
					end else begin
						c_q     <= c0;
						neg_q   <= dp[DELTA_W-1];
						den_q   <= dp_abs;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DLD;
				end
				ST_DLD: begin
					// load numerator of the first crossing
					dv_rem_q <= '0;
					dv_quo_q <= prod_mag;
					dv_neg_q <= prod_q[PRODW-1];
					dv_cnt_q <= DCW'(NW);
					state_q  <= ST_DIVA;
				end
				ST_DIVA: begin
					if (dv_cnt_q != '0) begin
						dv_rem_q <= dv_rem_n;
						dv_quo_q <= {dv_quo_q[NW-2:0], dv_ge};
						dv_cnt_q <= dv_cnt_q - DCW'(1);
					end else begin
						q_q      <= fin_q;
						r_q      <= fin_r;
						// load the per-crossing increment
						dv_rem_q <= '0;
						dv_quo_q <= NW'({ds_abs, {FRAC{1'b0}}});
						dv_neg_q <= ds[DELTA_W-1];
						dv_cnt_q <= DCW'(NW);
						state_q  <= ST_DIVB;
					end
				end
				ST_DIVB: begin
					if (dv_cnt_q != '0) begin
						dv_rem_q <= dv_rem_n;
						dv_quo_q <= {dv_quo_q[NW-2:0], dv_ge};
						dv_cnt_q <= dv_cnt_q - DCW'(1);
					end else begin
						qi_q    <= fin_q;
						ri_q    <= fin_r;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (!loop_ok || s_oob) begin
						state_q <= ST_NEXT;
					end else begin
						off_q   <= c_off;
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					if (off_q || (tile_rd_q == '0)) begin
						src_q <= SRC_EMPTY;
					end else if (TYW'(tile_rd_q) > TYW'(TILE_TYPES)) begin
						src_q <= SRC_ZERO;
					end else begin
						src_q <= SRC_MEM;
					end
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					if ((cell_f & filt_q) != '0) begin
						cand_x_q <= axis_q ? COORD_W'(s_cur) : COORD_W'(p_cur);
						cand_y_q <= axis_q ? COORD_W'(p_cur) : COORD_W'(s_cur);
						state_q  <= ST_SQ1;
					end else begin
						c_q     <= neg_q ? c_q - C_ONE : c_q + C_ONE;
						r_q     <= r_wrap ? DENW'(r_sum - {1'b0, den_q}) : DENW'(r_sum);
						q_q     <= q_q + qi_q + (r_wrap ? QW'(1) : QW'(0));
						state_q <= ST_STEP;
					end
				end
				ST_SQ1: begin
					state_q <= ST_SQ2;
				end
				ST_SQ2: begin
					sq_q    <= prod_u;
					state_q <= ST_SQ3;
				end
				ST_SQ3: begin
					// keep the nearer hit; x walk wins ties
					if (!found_q || (sq_sum < best_d_q)) begin
						found_q  <= 1'b1;
						best_d_q <= sq_sum;
						best_x_q <= cand_x_q;
						best_y_q <= cand_y_q;
					end
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_SETUP;
					end else begin
						state_q <= ST_LEN1;
					end
				end
				ST_LEN1: begin
					sq_q    <= prod_u;
					state_q <= ST_LEN2;
				end
				ST_LEN2: begin
					hit_bit_q <= found_q && (best_d_q <= sq_sum);
					state_q   <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the result register is free
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						res_hit_q   <= hit_bit_q;
						res_x_q     <= best_x_q;
						res_y_q     <= best_y_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// crossing remainders stay below the divisor
	`TGRC_ASSERT(a_rem_below_den, state_q == ST_STEP, r_q < den_q)
	`TGRC_ASSERT(a_inc_rem_below_den, state_q == ST_STEP, ri_q < den_q)
	// a result word only appears from the finish step
	`TGRC_ASSERT(a_result_from_fin, $rose(res_valid_q), $past(state_q == ST_FIN))

endmodule
